@@ design/bqmj_pkg.sv @@
// Shared types and constants for the bilinear quadrangle mapping block.
package bqmj_pkg;

  // Field widths and fixed-point formats
  localparam int COORD_W   = 24;  // signed Q8.16 corner and mapped coordinates
  localparam int REF_W     = 17;  // unsigned Q1.16 reference coordinates
  localparam int FRAC_W    = 16;  // fraction bits of coordinates
  localparam int DET_W     = 48;  // signed Q16.32 determinant terms
  localparam int NUM_REGS  = 8;
  localparam int CFG_IDX_W = 3;

  // Rounding shifts: weights are Q.32, the determinant is Q.64, its derivatives Q.48
  localparam int MAP_SHIFT   = 2 * FRAC_W;
  localparam int DET_SHIFT   = 2 * FRAC_W;
  localparam int DERIV_SHIFT = FRAC_W;

  localparam logic [REF_W-1:0]           REF_ONE   = REF_W'(1) << FRAC_W;
  localparam logic signed [COORD_W-1:0]  COORD_ONE = COORD_W'(1) << FRAC_W;
  localparam logic signed [COORD_W-1:0]  COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam logic signed [COORD_W-1:0]  COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};
  localparam logic signed [DET_W-1:0]    DET_MAX   = {1'b0, {(DET_W-1){1'b1}}};
  localparam logic signed [DET_W-1:0]    DET_MIN   = {1'b1, {(DET_W-1){1'b0}}};

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_C00_X = 3'd0,
    REG_C00_Y = 3'd1,
    REG_C01_X = 3'd2,
    REG_C01_Y = 3'd3,
    REG_C10_X = 3'd4,
    REG_C10_Y = 3'd5,
    REG_C11_X = 3'd6,
    REG_C11_Y = 3'd7
  } cfg_reg_t;

  // Unit square after reset
  localparam logic signed [COORD_W-1:0] CORNER_RESET [NUM_REGS] = '{
    '0, '0, '0, COORD_ONE, COORD_ONE, '0, COORD_ONE, COORD_ONE
  };

  typedef struct packed {
    logic [REF_W-1:0] s_coord;
    logic [REF_W-1:0] t_coord;
  } in_item_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] mapped_x;
    logic signed [COORD_W-1:0] mapped_y;
    logic signed [DET_W-1:0]   jacobian_det;
    logic signed [DET_W-1:0]   det_deriv_s;
    logic signed [DET_W-1:0]   det_deriv_t;
    logic                      orientation_negative;
  } out_item_t;

endpackage

@@ design/bilinear_quad_map_jacobian.sv @@
// Bilinear quadrangle mapping with Jacobian determinant, eight-stage pipeline.
//
// Maps each request (s,t) of the unit square onto the quadrangle held in the
// eight corner registers (index 0..7: c00 x/y, c01 x/y, c10 x/y, c11 x/y) and
// returns the mapped point, the Jacobian determinant, its derivatives along
// s and t, and the sign of the determinant at the origin. One request enters
// per cycle while the pipe is not stalled by the output. The depth is set by
// the determinant path: the 42 by 42 bit cross products are split into 21-bit
// halves whose four partial products are merged, subtracted and rounded
// over separate stages. Each stage holds its item under backpressure and
// takes a new one whenever it is empty or its item moves on, so bubbles are
// squeezed out while the output waits. Corner registers take effect for
// requests accepted after the write and are meant to be written while no
// request is in flight.
module bilinear_quad_map_jacobian (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  bqmj_pkg::in_item_t                    in_data,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output bqmj_pkg::out_item_t                   out_data,
  input  logic                                  cfg_wr_en,
  input  logic [bqmj_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [bqmj_pkg::COORD_W-1:0]          cfg_wdata
);
  import bqmj_pkg::*;

  localparam int NST  = 8;                        // pipeline stages
  localparam int EW   = COORD_W + 1;              // corner differences
  localparam int DW   = COORD_W + 2;              // mixed second derivative
  localparam int WW   = 2 * REF_W;                // bilinear weights
  localparam int TW   = REF_W + 1 + DW;           // t*dx style products
  localparam int JW   = COORD_W + FRAC_W + 2;     // first partials xs, ys, xt, yt
  localparam int JL   = JW / 2;                   // low split of a partial
  localparam int JH   = JW - JL;                  // high split of a partial
  localparam int OW   = 2 * EW;                   // orientation products
  localparam int MP   = WW + 1 + COORD_W;         // weight times corner
  localparam int MS   = MP + 1;                   // pair sum
  localparam int MA   = MP + 2;                   // full weighted sum
  localparam int MR   = MA + 1;                   // with rounding bias
  localparam int MRW  = MR - MAP_SHIFT;
  localparam int HHW  = 2 * JH;
  localparam int LLW  = 2 * JL;
  localparam int XW   = JH + JL + 1;              // cross partial
  localparam int XSW  = XW + 1;                   // sum of cross partials
  localparam int PW   = 2 * JW;                   // full determinant product
  localparam int QW   = JL + 1 + DW;              // derivative partial
  localparam int PDW  = JW + DW;                  // full derivative product
  localparam int PDX  = PDW + 1;                  // derivative difference
  localparam int DSR  = PDW + 2;                  // derivative with bias
  localparam int DV   = PW + 1;                   // determinant difference
  localparam int DVR  = DV + 1;                   // determinant with bias
  localparam int SATW_DET = DVR - DET_SHIFT;
  localparam int SATW_DS  = DSR - DERIV_SHIFT;
  localparam int SATW = (SATW_DET > SATW_DS) ? SATW_DET : SATW_DS;

  localparam logic signed [MR-1:0]   MAP_BIAS = MR'(1) <<< (MAP_SHIFT - 1);
  localparam logic signed [DVR-1:0]  DET_BIAS = DVR'(1) <<< (DET_SHIFT - 1);
  localparam logic signed [DSR-1:0]  DS_BIAS  = DSR'(1) <<< (DERIV_SHIFT - 1);
  localparam logic signed [MRW-1:0]  COORD_HI = MRW'(COORD_MAX);
  localparam logic signed [MRW-1:0]  COORD_LO = MRW'(COORD_MIN);
  localparam logic signed [SATW-1:0] DET_HI   = SATW'(DET_MAX);
  localparam logic signed [SATW-1:0] DET_LO   = SATW'(DET_MIN);

  function automatic logic signed [COORD_W-1:0] sat_coord(input logic signed [MRW-1:0] v);
    if (v > COORD_HI) begin
      return COORD_MAX;
    end else if (v < COORD_LO) begin
      return COORD_MIN;
    end
    return COORD_W'(v);
  endfunction

  function automatic logic signed [DET_W-1:0] sat_det(input logic signed [SATW-1:0] v);
    if (v > DET_HI) begin
      return DET_MAX;
    end else if (v < DET_LO) begin
      return DET_MIN;
    end
    return DET_W'(v);
  endfunction

  // ---------------------------------------------------------------- corners
  logic signed [COORD_W-1:0] corner_r [NUM_REGS];

  // Write a corner register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        corner_r[i] <= CORNER_RESET[i];
      end
    end else if (cfg_wr_en) begin
      corner_r[cfg_reg_t'(cfg_index)] <= cfg_wdata;
    end
  end

  logic signed [COORD_W-1:0] x00, y00, x01, y01, x10, y10, x11, y11;
  logic signed [EW-1:0]      ex_s, ey_s, ex_t, ey_t;
  logic signed [DW-1:0]      dx, dy;

  // Edge vectors, mixed term: user keeps them static while requests are in flight; unchecked
  always_comb begin
    x00  = corner_r[REG_C00_X];
    y00  = corner_r[REG_C00_Y];
    x01  = corner_r[REG_C01_X];
    y01  = corner_r[REG_C01_Y];
    x10  = corner_r[REG_C10_X];
    y10  = corner_r[REG_C10_Y];
    x11  = corner_r[REG_C11_X];
    y11  = corner_r[REG_C11_Y];
    ex_s = EW'(x10) - EW'(x00);
    ey_s = EW'(y10) - EW'(y00);
    ex_t = EW'(x01) - EW'(x00);
    ey_t = EW'(y01) - EW'(y00);
    dx   = (DW'(x00) + DW'(x11)) - (DW'(x01) + DW'(x10));
    dy   = (DW'(y00) + DW'(y11)) - (DW'(y01) + DW'(y10));
  end

  // ------------------------------------------------------- pipeline control
  logic [NST:1]   v_r;
  logic [NST+1:1] rdy;
  logic           in_fire, out_fire;

  // Stage k may load when it is empty or its item moves on
  always_comb begin
    rdy[NST+1] = out_ready;
    for (int k = NST; k >= 1; k--) begin
      rdy[k] = !v_r[k] || rdy[k+1];
    end
  end

  assign in_ready  = rdy[1];
  assign out_valid = v_r[NST];
  assign in_fire   = in_valid && in_ready;
  assign out_fire  = out_valid && out_ready;

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (rdy[1]) begin
        v_r[1] <= in_valid;
      end
      for (int k = 2; k <= NST; k++) begin
        if (rdy[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  // ------------------------------------------------------- stage registers
  logic [REF_W-1:0]          s1_r, t1_r, oms1_r, omt1_r;
  logic [REF_W-1:0]          s1_nxt, t1_nxt, oms1_nxt, omt1_nxt;

  logic [WW-1:0]             w2_r [4];
  logic [WW-1:0]             w2_nxt [4];
  logic signed [TW-1:0]      tdx2_r, tdy2_r, sdx2_r, sdy2_r;
  logic signed [TW-1:0]      tdx2_nxt, tdy2_nxt, sdx2_nxt, sdy2_nxt;
  logic signed [OW-1:0]      ora2_r, orb2_r, ora2_nxt, orb2_nxt;

  logic signed [MP-1:0]      px3_r [4];
  logic signed [MP-1:0]      py3_r [4];
  logic signed [MP-1:0]      px3_nxt [4];
  logic signed [MP-1:0]      py3_nxt [4];
  logic signed [JW-1:0]      xs3_r, ys3_r, xt3_r, yt3_r;
  logic signed [JW-1:0]      xs3_nxt, ys3_nxt, xt3_nxt, yt3_nxt;
  logic                      neg3_r, neg3_nxt;

  logic signed [MS-1:0]      ax4_r [2];
  logic signed [MS-1:0]      ay4_r [2];
  logic signed [MS-1:0]      ax4_nxt [2];
  logic signed [MS-1:0]      ay4_nxt [2];
  logic signed [HHW-1:0]     hh4_r [2];
  logic signed [HHW-1:0]     hh4_nxt [2];
  logic signed [XW-1:0]      hl4_r [2];
  logic signed [XW-1:0]      lh4_r [2];
  logic signed [XW-1:0]      hl4_nxt [2];
  logic signed [XW-1:0]      lh4_nxt [2];
  logic [LLW-1:0]            ll4_r [2];
  logic [LLW-1:0]            ll4_nxt [2];
  logic signed [QW-1:0]      dh4_r [4];
  logic signed [QW-1:0]      dl4_r [4];
  logic signed [QW-1:0]      dh4_nxt [4];
  logic signed [QW-1:0]      dl4_nxt [4];
  logic                      neg4_r;

  logic signed [MA-1:0]      accx5_r, accy5_r, accx5_nxt, accy5_nxt;
  logic signed [PW-1:0]      cat5_r [2];
  logic signed [PW-1:0]      cat5_nxt [2];
  logic signed [XSW-1:0]     crs5_r [2];
  logic signed [XSW-1:0]     crs5_nxt [2];
  logic signed [PDW-1:0]     pd5_r [4];
  logic signed [PDW-1:0]     pd5_nxt [4];
  logic                      neg5_r;

  logic signed [COORD_W-1:0] mx6_r, my6_r, mx6_nxt, my6_nxt;
  logic signed [PW-1:0]      pp6_r [2];
  logic signed [PW-1:0]      pp6_nxt [2];
  logic signed [PDX-1:0]     ds6_r, dt6_r, ds6_nxt, dt6_nxt;
  logic                      neg6_r;

  logic signed [COORD_W-1:0] mx7_r, my7_r;
  logic signed [DV-1:0]      dv7_r, dv7_nxt;
  logic signed [DET_W-1:0]   ds7_r, dt7_r, ds7_nxt, dt7_nxt;
  logic                      neg7_r;

  out_item_t                 out_r, out_nxt;

  // Operand views for the multiplies and rounding sums
  logic signed [JW-1:0]      det_a [2];
  logic signed [JW-1:0]      det_b [2];
  logic signed [JW-1:0]      drv_j [4];
  logic signed [DW-1:0]      drv_d [4];
  logic signed [COORD_W-1:0] cx [4];
  logic signed [COORD_W-1:0] cy [4];
  logic signed [MR-1:0]      mrx, mry;
  logic signed [DSR-1:0]     dsr, dtr;
  logic signed [DVR-1:0]     dvr;

  always_comb begin
    // Stage 1: clamp the reference point to the unit square
    s1_nxt   = (in_data.s_coord > REF_ONE) ? REF_ONE : in_data.s_coord;
    t1_nxt   = (in_data.t_coord > REF_ONE) ? REF_ONE : in_data.t_coord;
    oms1_nxt = REF_ONE - s1_nxt;
    omt1_nxt = REF_ONE - t1_nxt;

    // Stage 2: bilinear weights, mixed-term products, origin cross products
    w2_nxt[0] = WW'(oms1_r) * WW'(omt1_r);
    w2_nxt[1] = WW'(s1_r)   * WW'(omt1_r);
    w2_nxt[2] = WW'(oms1_r) * WW'(t1_r);
    w2_nxt[3] = WW'(s1_r)   * WW'(t1_r);
    tdx2_nxt  = TW'(signed'({1'b0, t1_r})) * TW'(dx);
    tdy2_nxt  = TW'(signed'({1'b0, t1_r})) * TW'(dy);
    sdx2_nxt  = TW'(signed'({1'b0, s1_r})) * TW'(dx);
    sdy2_nxt  = TW'(signed'({1'b0, s1_r})) * TW'(dy);
    ora2_nxt  = OW'(ex_s) * OW'(ey_t);
    orb2_nxt  = OW'(ey_s) * OW'(ex_t);

    // Stage 3: weighted corners, first partials, orientation sign
    cx = '{x00, x10, x01, x11};
    cy = '{y00, y10, y01, y11};
    for (int i = 0; i < 4; i++) begin
      px3_nxt[i] = MP'(signed'({1'b0, w2_r[i]})) * MP'(cx[i]);
      py3_nxt[i] = MP'(signed'({1'b0, w2_r[i]})) * MP'(cy[i]);
    end
    xs3_nxt  = JW'((TW'(ex_s) <<< FRAC_W) + tdx2_r);
    ys3_nxt  = JW'((TW'(ey_s) <<< FRAC_W) + tdy2_r);
    xt3_nxt  = JW'((TW'(ex_t) <<< FRAC_W) + sdx2_r);
    yt3_nxt  = JW'((TW'(ey_t) <<< FRAC_W) + sdy2_r);
    neg3_nxt = ora2_r < orb2_r;

    // Stage 4: pair sums of the map, split partial products of the cross and derivative terms
    ax4_nxt[0] = MS'(px3_r[0]) + MS'(px3_r[1]);
    ax4_nxt[1] = MS'(px3_r[2]) + MS'(px3_r[3]);
    ay4_nxt[0] = MS'(py3_r[0]) + MS'(py3_r[1]);
    ay4_nxt[1] = MS'(py3_r[2]) + MS'(py3_r[3]);
    det_a = '{xs3_r, ys3_r};
    det_b = '{yt3_r, xt3_r};
    for (int i = 0; i < 2; i++) begin
      hh4_nxt[i] = HHW'(signed'(det_a[i][JW-1:JL])) * HHW'(signed'(det_b[i][JW-1:JL]));
      hl4_nxt[i] = XW'(signed'(det_a[i][JW-1:JL])) * XW'(signed'({1'b0, det_b[i][JL-1:0]}));
      lh4_nxt[i] = XW'(signed'({1'b0, det_a[i][JL-1:0]})) * XW'(signed'(det_b[i][JW-1:JL]));
      ll4_nxt[i] = LLW'(det_a[i][JL-1:0]) * LLW'(det_b[i][JL-1:0]);
    end
    drv_j = '{xs3_r, ys3_r, yt3_r, xt3_r};
    drv_d = '{dy, dx, dx, dy};
    for (int i = 0; i < 4; i++) begin
      dh4_nxt[i] = QW'(signed'(drv_j[i][JW-1:JL])) * QW'(drv_d[i]);
      dl4_nxt[i] = QW'(signed'({1'b0, drv_j[i][JL-1:0]})) * QW'(drv_d[i]);
    end

    // Stage 5: finish the map sums, merge partials
    accx5_nxt = MA'(ax4_r[0]) + MA'(ax4_r[1]);
    accy5_nxt = MA'(ay4_r[0]) + MA'(ay4_r[1]);
    for (int i = 0; i < 2; i++) begin
      cat5_nxt[i] = signed'({hh4_r[i], ll4_r[i]});
      crs5_nxt[i] = XSW'(hl4_r[i]) + XSW'(lh4_r[i]);
    end
    for (int i = 0; i < 4; i++) begin
      pd5_nxt[i] = (PDW'(dh4_r[i]) <<< JL) + PDW'(dl4_r[i]);
    end

    // Stage 6: round and saturate the map, full products, derivative differences
    mrx     = MR'(accx5_r) + MAP_BIAS;
    mry     = MR'(accy5_r) + MAP_BIAS;
    mx6_nxt = sat_coord(signed'(mrx[MR-1:MAP_SHIFT]));
    my6_nxt = sat_coord(signed'(mry[MR-1:MAP_SHIFT]));
    for (int i = 0; i < 2; i++) begin
      pp6_nxt[i] = cat5_r[i] + (PW'(crs5_r[i]) <<< JL);
    end
    ds6_nxt = PDX'(pd5_r[0]) - PDX'(pd5_r[1]);
    dt6_nxt = PDX'(pd5_r[2]) - PDX'(pd5_r[3]);

    // Stage 7: determinant difference, round and saturate the derivatives
    dv7_nxt = DV'(pp6_r[0]) - DV'(pp6_r[1]);
    dsr     = DSR'(ds6_r) + DS_BIAS;
    dtr     = DSR'(dt6_r) + DS_BIAS;
    ds7_nxt = sat_det(SATW'(signed'(dsr[DSR-1:DERIV_SHIFT])));
    dt7_nxt = sat_det(SATW'(signed'(dtr[DSR-1:DERIV_SHIFT])));

    // Stage 8: round and saturate the determinant, assemble the result
    dvr = DVR'(dv7_r) + DET_BIAS;
    out_nxt.mapped_x             = mx7_r;
    out_nxt.mapped_y             = my7_r;
    out_nxt.jacobian_det         = sat_det(SATW'(signed'(dvr[DVR-1:DET_SHIFT])));
    out_nxt.det_deriv_s          = ds7_r;
    out_nxt.det_deriv_t          = dt7_r;
    out_nxt.orientation_negative = neg7_r;
  end

  // Load each stage when it may advance
  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      s1_r   <= s1_nxt;
      t1_r   <= t1_nxt;
      oms1_r <= oms1_nxt;
      omt1_r <= omt1_nxt;
    end
    if (rdy[2]) begin
      w2_r   <= w2_nxt;
      tdx2_r <= tdx2_nxt;
      tdy2_r <= tdy2_nxt;
      sdx2_r <= sdx2_nxt;
      sdy2_r <= sdy2_nxt;
      ora2_r <= ora2_nxt;
      orb2_r <= orb2_nxt;
    end
    if (rdy[3]) begin
      px3_r  <= px3_nxt;
      py3_r  <= py3_nxt;
      xs3_r  <= xs3_nxt;
      ys3_r  <= ys3_nxt;
      xt3_r  <= xt3_nxt;
      yt3_r  <= yt3_nxt;
      neg3_r <= neg3_nxt;
    end
    if (rdy[4]) begin
      ax4_r  <= ax4_nxt;
      ay4_r  <= ay4_nxt;
      hh4_r  <= hh4_nxt;
      hl4_r  <= hl4_nxt;
      lh4_r  <= lh4_nxt;
      ll4_r  <= ll4_nxt;
      dh4_r  <= dh4_nxt;
      dl4_r  <= dl4_nxt;
      neg4_r <= neg3_r;
    end
    if (rdy[5]) begin
      accx5_r <= accx5_nxt;
      accy5_r <= accy5_nxt;
      cat5_r  <= cat5_nxt;
      crs5_r  <= crs5_nxt;
      pd5_r   <= pd5_nxt;
      neg5_r  <= neg4_r;
    end
    if (rdy[6]) begin
      mx6_r  <= mx6_nxt;
      my6_r  <= my6_nxt;
      pp6_r  <= pp6_nxt;
      ds6_r  <= ds6_nxt;
      dt6_r  <= dt6_nxt;
      neg6_r <= neg5_r;
    end
    if (rdy[7]) begin
      mx7_r  <= mx6_r;
      my7_r  <= my6_r;
      dv7_r  <= dv7_nxt;
      ds7_r  <= ds7_nxt;
      dt7_r  <= dt7_nxt;
      neg7_r <= neg6_r;
    end
    if (rdy[8]) begin
      out_r <= out_nxt;
    end
  end

  assign out_data = out_r;

  // ------------------------------------------------------------ assertions
  // An empty output stage leaves the whole pipe open for a request
  a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
    !v_r[NST] |-> in_ready)
    else $error("input blocked while the output stage is empty");

  // A full pipe with a stalled output must refuse requests
  a_full_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (&v_r && !out_ready) |-> !in_ready)
    else $error("request accepted into a full stalled pipe");

  // An accepted request lands in the first stage
  a_enter: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> v_r[1])
    else $error("accepted request missing from stage 1");

  // Items in flight change only by requests in and results out
  a_conserve: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |=> ($countones(v_r) ==
              $past($countones(v_r)) + int'($past(in_fire)) - int'($past(out_fire))))
    else $error("item lost or duplicated in the pipe");

endmodule

@@ tb/sv/tb_bilinear_quad_map_jacobian.sv @@
// Self-checking testbench for the bilinear quadrangle mapping and Jacobian block.
module tb_bilinear_quad_map_jacobian;
  timeunit 1ns;
  timeprecision 1ps;

  import bqmj_pkg::*;

  typedef logic signed [127:0] wide_t;
  typedef logic signed [COORD_W-1:0] coord_t;

  localparam longint UNIT = 65536;
  localparam int LONG_HOLD = 300;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  in_item_t in_data;
  logic out_valid;
  logic out_ready;
  out_item_t out_data;
  logic cfg_wr_en;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [COORD_W-1:0] cfg_wdata;

  // Corner registers as the block should hold them
  coord_t quad_corner [NUM_REGS];
  out_item_t expected_maps [$];
  int mismatch_count;
  int send_idle_pct;
  int recv_stall_pct;
  bit hold_off_req;
  bit hold_off_done;
  int hold_off_left;

  bilinear_quad_map_jacobian uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #6 clk = ~clk;

  // Round half up by 2^32 and saturate to a coordinate
  function automatic coord_t round_coord(input longint acc);
    longint r;
    r = (acc + (longint'(1) <<< 31)) >>> 32;
    if (r > longint'(COORD_MAX)) r = longint'(COORD_MAX);
    if (r < longint'(COORD_MIN)) r = longint'(COORD_MIN);
    return r[COORD_W-1:0];
  endfunction

  // Round half up by 2^k and saturate to a determinant term
  function automatic logic signed [DET_W-1:0] round_det(input wide_t v, input int k);
    wide_t r;
    r = (v + (wide_t'(1) <<< (k - 1))) >>> k;
    if (r > wide_t'(DET_MAX)) r = wide_t'(DET_MAX);
    if (r < wide_t'(DET_MIN)) r = wide_t'(DET_MIN);
    return r[DET_W-1:0];
  endfunction

  function automatic wide_t cross_diff(input longint a, input longint b,
                                       input longint c, input longint d);
    return wide_t'(a) * wide_t'(b) - wide_t'(c) * wide_t'(d);
  endfunction

  // Map one request onto the current quadrangle
  function automatic out_item_t map_point(input in_item_t req);
    longint s, t, w00, w10, w01, w11;
    longint x00, y00, x01, y01, x10, y10, x11, y11;
    longint dx, dy, xs, ys, xt, yt;
    out_item_t r;
    s = longint'(req.s_coord);
    t = longint'(req.t_coord);
    // clamp reference coordinates above one
    if (s > UNIT) s = UNIT;
    if (t > UNIT) t = UNIT;
    x00 = longint'(quad_corner[REG_C00_X]);
    y00 = longint'(quad_corner[REG_C00_Y]);
    x01 = longint'(quad_corner[REG_C01_X]);
    y01 = longint'(quad_corner[REG_C01_Y]);
    x10 = longint'(quad_corner[REG_C10_X]);
    y10 = longint'(quad_corner[REG_C10_Y]);
    x11 = longint'(quad_corner[REG_C11_X]);
    y11 = longint'(quad_corner[REG_C11_Y]);
    w00 = (UNIT - s) * (UNIT - t);
    w10 = s * (UNIT - t);
    w01 = (UNIT - s) * t;
    w11 = s * t;
    r.mapped_x = round_coord(w00 * x00 + w10 * x10 + w01 * x01 + w11 * x11);
    r.mapped_y = round_coord(w00 * y00 + w10 * y10 + w01 * y01 + w11 * y11);
    // twist term and first partials
    dx = x00 - x01 - x10 + x11;
    dy = y00 - y01 - y10 + y11;
    xs = (x10 - x00) * UNIT + t * dx;
    ys = (y10 - y00) * UNIT + t * dy;
    xt = (x01 - x00) * UNIT + s * dx;
    yt = (y01 - y00) * UNIT + s * dy;
    r.jacobian_det = round_det(cross_diff(xs, yt, ys, xt), DET_SHIFT);
    r.det_deriv_s  = round_det(cross_diff(xs, dy, ys, dx), DERIV_SHIFT);
    r.det_deriv_t  = round_det(cross_diff(dx, yt, dy, xt), DERIV_SHIFT);
    r.orientation_negative =
      cross_diff(x10 - x00, y01 - y00, y10 - y00, x01 - x00) < 0;
    return r;
  endfunction

  function automatic logic [REF_W-1:0] random_ref_coord();
    case ($urandom_range(19))
      0: return '0;
      1: return REF_ONE;
      2, 3: return REF_W'($urandom_range(65537, 131071));
      default: return REF_W'($urandom_range(0, 65536));
    endcase
  endfunction

  function automatic coord_t random_corner_value();
    int v;
    case ($urandom_range(3))
      0: return coord_t'($urandom);
      3: begin
        case ($urandom_range(3))
          0: return COORD_MAX;
          1: return COORD_MIN;
          2: return '0;
          default: return COORD_ONE;
        endcase
      end
      default: begin
        v = int'($urandom_range(0, 524288)) - 262144;
        return coord_t'(v);
      end
    endcase
  endfunction

  task automatic compare_field(input string name, input logic [DET_W-1:0] want,
                               input logic [DET_W-1:0] got);
    if (want !== got) begin
      mismatch_count++;
      $display("%0t: %s expected %h actual %h", $time, name, want, got);
    end
  endtask

  // Check each accepted result against the oldest prediction
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_maps.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected result expected none actual %h", $time, out_data);
      end else begin
        want = expected_maps.pop_front();
        compare_field("mapped_x", DET_W'(unsigned'(want.mapped_x)),
                      DET_W'(unsigned'(out_data.mapped_x)));
        compare_field("mapped_y", DET_W'(unsigned'(want.mapped_y)),
                      DET_W'(unsigned'(out_data.mapped_y)));
        compare_field("jacobian_det", want.jacobian_det, out_data.jacobian_det);
        compare_field("det_deriv_s", want.det_deriv_s, out_data.det_deriv_s);
        compare_field("det_deriv_t", want.det_deriv_t, out_data.det_deriv_t);
        compare_field("orientation_negative", DET_W'(want.orientation_negative),
                      DET_W'(out_data.orientation_negative));
      end
    end
  end

  // Drive the result ready: random stalls plus one long hold-off on request
  always @(posedge clk) begin
    if (hold_off_req && !hold_off_done) begin
      hold_off_left = LONG_HOLD;
      hold_off_done = 1'b1;
    end
    if (hold_off_left > 0) begin
      out_ready <= 1'b0;
      hold_off_left--;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Offer one request and record its prediction once accepted
  task automatic send_point(input in_item_t req);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= req;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_maps.push_back(map_point(req));
  endtask

  task automatic send_st(input int s, input int t);
    in_item_t req;
    req.s_coord = REF_W'(s);
    req.t_coord = REF_W'(t);
    send_point(req);
  endtask

  // Drop valid and wait until every result is back and the pipe is empty
  task automatic drain_requests();
    int guard;
    guard = 0;
    in_valid <= 1'b0;
    while (expected_maps.size() != 0 && guard < 50000) begin
      @(posedge clk);
      guard++;
    end
    repeat (12) @(posedge clk);
  endtask

  // Write all eight corners, one per cycle, while idle
  task automatic load_corners(input coord_t vals [NUM_REGS]);
    for (int i = 0; i < NUM_REGS; i++) begin
      cfg_wr_en <= 1'b1;
      cfg_index <= CFG_IDX_W'(i);
      cfg_wdata <= vals[i];
      @(posedge clk);
      quad_corner[i] = vals[i];
    end
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_quad(input coord_t x00, input coord_t y00, input coord_t x01,
                          input coord_t y01, input coord_t x10, input coord_t y10,
                          input coord_t x11, input coord_t y11);
    coord_t vals [NUM_REGS];
    vals[REG_C00_X] = x00;
    vals[REG_C00_Y] = y00;
    vals[REG_C01_X] = x01;
    vals[REG_C01_Y] = y01;
    vals[REG_C10_X] = x10;
    vals[REG_C10_Y] = y10;
    vals[REG_C11_X] = x11;
    vals[REG_C11_Y] = y11;
    drain_requests();
    load_corners(vals);
  endtask

  task automatic load_random_quad();
    coord_t vals [NUM_REGS];
    foreach (vals[i]) vals[i] = random_corner_value();
    drain_requests();
    load_corners(vals);
  endtask

  // Unit square after reset: corners, center, and coordinates above one
  task automatic test_reset_square();
    send_st(0, 0);
    send_st(65536, 65536);
    send_st(65536, 0);
    send_st(0, 65536);
    send_st(131071, 131071);
    send_st(65537, 32768);
    send_st(32768, 32768);
    send_st(21845, 109226);
  endtask

  // Saturating, flipped and degenerate quadrangles
  task automatic test_extreme_quads();
    // huge positive determinant
    set_quad(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX,
             COORD_MAX, COORD_MIN, COORD_MAX, COORD_MAX);
    send_st(0, 0);
    send_st(65536, 65536);
    send_st(131071, 0);
    send_st(40000, 12345);
    // huge negative determinant
    set_quad(COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX,
             COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX);
    send_st(0, 0);
    send_st(65536, 65536);
    send_st(0, 131071);
    send_st(54321, 777);
    // transposed square: negative orientation
    set_quad('0, '0, COORD_ONE, '0, '0, COORD_ONE, COORD_ONE, COORD_ONE);
    send_st(0, 0);
    send_st(65536, 65536);
    send_st(100000, 3);
    send_st(16384, 49152);
    // all corners equal: zero determinant at the origin
    set_quad(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX,
             COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX);
    send_st(0, 0);
    send_st(65536, 65536);
    send_st(131071, 131071);
    send_st(30000, 60000);
  endtask

  // Random requests over random quadrangles, reloading every so often
  task automatic test_random_quads(input int count, input int send_pct, input int recv_pct);
    in_item_t req;
    int until_reload;
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
    until_reload = 0;
    for (int n = 0; n < count; n++) begin
      if (until_reload == 0) begin
        load_random_quad();
        until_reload = $urandom_range(50, 150);
      end
      until_reload--;
      req.s_coord = random_ref_coord();
      req.t_coord = random_ref_coord();
      send_point(req);
    end
  endtask

  // Hold the output off for a long stretch while requests keep coming
  task automatic test_backpressure_fill();
    in_item_t req;
    drain_requests();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_off_req = 1'b1;
    for (int n = 0; n < 60; n++) begin
      req.s_coord = random_ref_coord();
      req.t_coord = random_ref_coord();
      send_point(req);
    end
  endtask

  initial begin
    #5_000_000;
    $display("Mismatches found");
    $finish;
  end

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_wr_en = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    hold_off_req = 1'b0;
    send_idle_pct = 9;
    recv_stall_pct = 68;
    foreach (quad_corner[i]) quad_corner[i] = CORNER_RESET[i];
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_square();
    test_extreme_quads();
    test_random_quads(400, 9, 68);
    test_random_quads(400, 68, 9);
    test_backpressure_fill();
    test_random_quads(400, 0, 0);

    drain_requests();
    if (expected_maps.size() != 0) begin
      $display("%0t: missing results expected %0d actual 0", $time, expected_maps.size());
    end
    if (mismatch_count == 0 && expected_maps.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
